/* src/lsspd_pkg.sv */
// Shared types and constants for the line sensor steering PD core.
// Used by lsspd_scan, lsspd_pd and line_sensor_steering_pd_core; no dependencies.
`default_nettype none

package lsspd_pkg;

  // Sensor bar geometry
  localparam int NUM_SENSORS = 16;
  localparam int FLAG_W      = 16;
  localparam int IDX_W       = 4;

  // Gains and angle
  localparam int GAIN_W  = 11;
  localparam int CORR_W  = 16;
  localparam int ANGLE_W = 15;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 15'd18000;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 15'd9000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 2'd2;

  localparam logic [IDX_W-1:0]  CENTER_RESET = 4'd7;
  localparam logic [GAIN_W-1:0] KP_RESET     = 11'd100;
  localparam logic [GAIN_W-1:0] KD_RESET     = 11'd0;

  typedef logic [FLAG_W-1:0] flag_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Ordering key for run selection: width first, then start (later run wins)
  typedef struct packed {
    idx_t width;
    idx_t first;
  } key_t;

  typedef struct packed {
    idx_t                     center;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
  } cfg_t;

  typedef struct packed {
    idx_t first;
    idx_t last;
  } run_t;

  typedef struct packed {
    idx_t                      run_start;
    idx_t                      run_end;
    idx_t                      line_position;
    logic                      line_found;
    logic signed [CORR_W-1:0]  pd_correction;
    logic [ANGLE_W-1:0]        steer_angle;
  } res_t;

  // Lowest index i such that sensors i..j are all set (j itself if only j)
  function automatic idx_t run_first(input flag_t f, input int j);
    flag_t m;
    idx_t  s;
    s = idx_t'(j);
    for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
      for (int k = 0; k < FLAG_W; k++) begin
        m[k] = (k >= i) && (k <= j);
      end
      if ((i <= j) && ((f & m) == m)) begin
        s = idx_t'(i);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/lsspd_scan.sv */
// Run scanner: finds the widest run of set sensor bits, later run wins a tie.
// Depends on lsspd_pkg. Purely combinational; sits between two pipeline registers.
`default_nettype none

module lsspd_scan (
  input  wire lsspd_pkg::flag_t flags,
  output lsspd_pkg::run_t       run
);

  localparam int NS = lsspd_pkg::NUM_SENSORS;

  lsspd_pkg::key_t cand [NS];
  lsspd_pkg::key_t node [2*NS];
  logic [NS-1:0]   is_end;
  lsspd_pkg::idx_t first;

  // One candidate per possible run end; each end knows its own start
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if (j == NS - 1) begin
        is_end[j] = flags[j];
      end else begin
        is_end[j] = flags[j] & ~flags[j+1];
      end
      first = lsspd_pkg::run_first(flags, j);
      if (is_end[j]) begin
        cand[j].width = lsspd_pkg::idx_t'(j) - first;
        cand[j].first = first;
      end else begin
        cand[j] = '0;
      end
    end
  end

  // Balanced max tree over the candidates
  always_comb begin
    node[0] = '0;
    for (int j = 0; j < NS; j++) begin
      node[NS+j] = cand[j];
    end
    for (int n = NS - 1; n >= 1; n--) begin
      node[n] = (node[2*n+1] >= node[2*n]) ? node[2*n+1] : node[2*n];
    end
  end

  assign run.first = node[1].first;
  assign run.last  = node[1].first + node[1].width;

endmodule

`default_nettype wire

/* src/lsspd_pd.sv */
// PD steering update: midpoint, correction, saturated angle, plus the
// previous-position and angle state. Depends on lsspd_pkg.
`default_nettype none

module lsspd_pd (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire lsspd_pkg::cfg_t cfg,
  input  wire lsspd_pkg::run_t run,
  input  wire                  upd,
  output lsspd_pkg::res_t      res
);

  localparam int IW = lsspd_pkg::IDX_W;
  localparam int GW = lsspd_pkg::GAIN_W;
  localparam int CW = lsspd_pkg::CORR_W;
  localparam int AW = lsspd_pkg::ANGLE_W;
  localparam int PW = GW + IW + 1;

  lsspd_pkg::idx_t          prev_pos_r, prev_pos_nxt;
  logic [AW-1:0]            angle_r, angle_nxt;

  lsspd_pkg::idx_t          mid;
  logic                     found;
  logic signed [IW:0]       err_p, err_d;
  logic signed [PW-1:0]     prod_p, prod_d;
  logic signed [PW:0]       corr_sum;
  logic signed [CW-1:0]     corr;
  logic signed [AW+2:0]     angle_sum;
  logic [AW-1:0]            angle_sat;

  // Midpoint of the run, rounded down
  assign mid   = IW'(({1'b0, run.first} + {1'b0, run.last}) >> 1);
  assign found = (mid != '0);

  // Correction terms
  always_comb begin
    err_p    = $signed({1'b0, cfg.center}) - $signed({1'b0, mid});
    err_d    = $signed({1'b0, mid}) - $signed({1'b0, prev_pos_r});
    prod_p   = err_p * $signed(cfg.kp);
    prod_d   = err_d * $signed(cfg.kd);
    corr_sum = {prod_p[PW-1], prod_p} + {prod_d[PW-1], prod_d};
    if (corr_sum > $signed((PW+1)'(32767))) begin
      corr = 16'sh7FFF;
    end else if (corr_sum < -$signed((PW+1)'(32768))) begin
      corr = -16'sh8000;
    end else begin
      corr = CW'(corr_sum);
    end
  end

  // Angle update, saturated to 0..ANGLE_MAX
  always_comb begin
    angle_sum = $signed({3'b000, angle_r}) + (AW+3)'(corr);
    if (angle_sum < 0) begin
      angle_sat = '0;
    end else if (angle_sum > $signed({3'b000, lsspd_pkg::ANGLE_MAX})) begin
      angle_sat = lsspd_pkg::ANGLE_MAX;
    end else begin
      angle_sat = AW'(angle_sum);
    end
  end

  // Next state
  always_comb begin
    prev_pos_nxt = prev_pos_r;
    angle_nxt    = angle_r;
    if (upd) begin
      if (found) begin
        prev_pos_nxt = mid;
        angle_nxt    = angle_sat;
      end else begin
        prev_pos_nxt = cfg.center;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pos_r <= lsspd_pkg::CENTER_RESET;
      angle_r    <= lsspd_pkg::ANGLE_RESET;
    end else begin
      prev_pos_r <= prev_pos_nxt;
      angle_r    <= angle_nxt;
    end
  end

  // Result beat for this item
  always_comb begin
    res.run_start     = run.first;
    res.run_end       = run.last;
    res.line_position = mid;
    res.line_found    = found;
    res.pd_correction = found ? corr : '0;
    res.steer_angle   = found ? angle_sat : angle_r;
  end

endmodule

`default_nettype wire

/* src/line_sensor_steering_pd_core.sv */
// Top level of the line sensor steering PD core: channels, pipeline, config.
// Depends on lsspd_pkg, lsspd_scan and lsspd_pd.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | input     | in_valid / in_ready  | in_sensor_flags
//   out_    | output    | out_valid / out_ready| run_start, run_end, line_position,
//           |           |                      | line_found, pd_correction, steer_angle
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Three register stages: input register, scan register, result register.
// One beat per cycle sustained while out_ready stays high; a stall holds the flow.
// The scan stage sets the run; the PD stage updates angle state as a beat enters
// the result register. Each stage holds under a stall and takes a new beat when
// the stage after it frees up. Synchronous reset restores gains, center and state.
`default_nettype none

module line_sensor_steering_pd_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [lsspd_pkg::FLAG_W-1:0]      in_sensor_flags,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [lsspd_pkg::IDX_W-1:0]       out_run_start,
  output logic [lsspd_pkg::IDX_W-1:0]       out_run_end,
  output logic [lsspd_pkg::IDX_W-1:0]       out_line_position,
  output logic                              out_line_found,
  output logic signed [lsspd_pkg::CORR_W-1:0] out_pd_correction,
  output logic [lsspd_pkg::ANGLE_W-1:0]     out_steer_angle,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [lsspd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [lsspd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lsspd_pkg::cfg_t  cfg_r;
  logic             v1_r, v1_nxt;
  lsspd_pkg::flag_t flags_r;
  logic             v2_r, v2_nxt;
  lsspd_pkg::run_t  run_r;
  logic             vo_r, vo_nxt;
  lsspd_pkg::res_t  res_r;

  lsspd_pkg::run_t  run_c;
  lsspd_pkg::res_t  res_c;
  logic             in_acc, s2_load, out_load;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= lsspd_pkg::CENTER_RESET;
      cfg_r.kp     <= lsspd_pkg::KP_RESET;
      cfg_r.kd     <= lsspd_pkg::KD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsspd_pkg::REG_CENTER: cfg_r.center <= cfg_data[lsspd_pkg::IDX_W-1:0];
        lsspd_pkg::REG_KP:     cfg_r.kp     <= cfg_data[lsspd_pkg::GAIN_W-1:0];
        lsspd_pkg::REG_KD:     cfg_r.kd     <= cfg_data[lsspd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance
  assign out_load = v2_r && (!vo_r || out_ready);
  assign s2_load  = v1_r && (!v2_r || out_load);
  assign in_ready = !v1_r || s2_load;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    v1_nxt = in_acc ? 1'b1 : (s2_load ? 1'b0 : v1_r);
    v2_nxt = s2_load ? 1'b1 : (out_load ? 1'b0 : v2_r);
    vo_nxt = out_load ? 1'b1 : ((vo_r && out_ready) ? 1'b0 : vo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flags_r <= in_sensor_flags;
    end
    if (s2_load) begin
      run_r <= run_c;
    end
    if (out_load) begin
      res_r <= res_c;
    end
  end

  lsspd_scan u_scan (
    .flags (flags_r),
    .run   (run_c)
  );

  lsspd_pd u_pd (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .run   (run_r),
    .upd   (out_load),
    .res   (res_c)
  );

  // Result beat
  assign out_valid         = vo_r;
  assign out_run_start     = res_r.run_start;
  assign out_run_end       = res_r.run_end;
  assign out_line_position = res_r.line_position;
  assign out_line_found    = res_r.line_found;
  assign out_pd_correction = res_r.pd_correction;
  assign out_steer_angle   = res_r.steer_angle;

endmodule

`default_nettype wire

/* src/lsspd_checker.sv */
// Port-level checks for line_sensor_steering_pd_core, bound to the top level.
// Depends on lsspd_pkg.
`default_nettype none

module lsspd_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire [lsspd_pkg::IDX_W-1:0]          out_run_start,
  input wire [lsspd_pkg::IDX_W-1:0]          out_run_end,
  input wire [lsspd_pkg::IDX_W-1:0]          out_line_position,
  input wire                                 out_line_found,
  input wire [lsspd_pkg::CORR_W-1:0]         out_pd_correction,
  input wire [lsspd_pkg::ANGLE_W-1:0]        out_steer_angle
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steer_angle)
      && $stable(out_line_position) && $stable(out_pd_correction))
    else $error("result beat changed under stall");

  // Angle stays in servo range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_steer_angle <= lsspd_pkg::ANGLE_MAX)
    else $error("steer angle out of range");

  // Midpoint matches the reported run and found flag
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_position ==
      lsspd_pkg::IDX_W'(({1'b0, out_run_start} + {1'b0, out_run_end}) >> 1))
      && (out_line_found == (out_line_position != '0)))
    else $error("midpoint inconsistent with run");

  // Run never ends before it starts
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_end >= out_run_start)
    else $error("run end below run start");

  // No correction when the line is lost
  a_lost_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_found |-> out_pd_correction == '0)
    else $error("correction applied with line lost");

endmodule

bind line_sensor_steering_pd_core lsspd_checker u_lsspd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_run_start     (out_run_start),
  .out_run_end       (out_run_end),
  .out_line_position (out_line_position),
  .out_line_found    (out_line_found),
  .out_pd_correction (out_pd_correction),
  .out_steer_angle   (out_steer_angle)
);

`default_nettype wire

/* test/line_sensor_steering_pd_core_tb.sv */
// Self-checking testbench for line_sensor_steering_pd_core: run scan, PD update, angle clamp.
// Depends on lsspd_pkg and the core RTL; predicts every result beat and compares it field by
// field, with random input bursts, output stalls and several center/gain settings.
module line_sensor_steering_pd_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lsspd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES        = 10;
  localparam int READINGS_PER  = 63;
  localparam int LONG_HOLD     = 60;

  logic                                   clk;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  lsspd_pkg::flag_t                       in_sensor_flags = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  lsspd_pkg::idx_t                        out_run_start;
  lsspd_pkg::idx_t                        out_run_end;
  lsspd_pkg::idx_t                        out_line_position;
  logic                                   out_line_found;
  logic signed [lsspd_pkg::CORR_W-1:0]    out_pd_correction;
  logic [lsspd_pkg::ANGLE_W-1:0]          out_steer_angle;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [lsspd_pkg::CFG_IDX_W-1:0]        cfg_index = lsspd_pkg::REG_CENTER;
  logic [lsspd_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  // Predictor copy of the registers and the steering state
  lsspd_pkg::idx_t                     cfg_center;
  logic signed [lsspd_pkg::GAIN_W-1:0] cfg_kp;
  logic signed [lsspd_pkg::GAIN_W-1:0] cfg_kd;
  lsspd_pkg::idx_t                     prev_mid;
  int                                  angle_now;

  lsspd_pkg::flag_t pending_readings [$];
  lsspd_pkg::res_t  expected_results [$];

  int readings_sent   = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int mismatches      = 0;
  int long_stall_reqs = 0;
  int long_stall_seen = 0;

  // Line readings: edges, full bar, ties between equal runs, lost line
  lsspd_pkg::flag_t directed_readings [18] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h0003, 16'h0007, 16'h0006,
    16'h8000, 16'hC000, 16'h5555, 16'hAAAA, 16'h0F0F, 16'h0FF0,
    16'hF00F, 16'h0180, 16'h7FFE, 16'h8001, 16'h00F0, 16'h0000};

  // Fixed settings, extremes first; later phases pick random register values
  int center_tab [6] = '{0, 15, 7, 3, 12, 15};
  int kp_tab     [6] = '{1000, -1000, 1023, -1024, -250, 37};
  int kd_tab     [6] = '{-1000, 1000, -1024, 1023, 500, 0};

  line_sensor_steering_pd_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_flags   (in_sensor_flags),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_run_start     (out_run_start),
    .out_run_end       (out_run_end),
    .out_line_position (out_line_position),
    .out_line_found    (out_line_found),
    .out_pd_correction (out_pd_correction),
    .out_steer_angle   (out_steer_angle),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Widest run (later run wins a tie), midpoint, PD step and angle clamp
  function automatic lsspd_pkg::res_t steer_predict(input lsspd_pkg::flag_t flags);
    lsspd_pkg::res_t r;
    int   s, e, bs, be, bw, mid, corr, ang;
    bit   run, lit;
    s = 0; e = 0; bs = 0; be = 0; bw = 0; corr = 0; run = 1'b0;
    // one extra step past the top sensor closes a run that reaches it
    for (int i = 0; i <= lsspd_pkg::NUM_SENSORS; i++) begin
      lit = (i < lsspd_pkg::FLAG_W) ? flags[i] : 1'b0;
      if (lit) begin
        if (!run) begin
          s   = i;
          run = 1'b1;
        end
        e = i;
      end else if (run) begin
        run = 1'b0;
        if (e - s >= bw) begin
          bw = e - s;
          bs = s;
          be = e;
        end
      end
    end
    mid = (bs + be) / 2;
    if (mid != 0) begin
      corr = (int'(cfg_center) - mid) * int'(cfg_kp) + (mid - int'(prev_mid)) * int'(cfg_kd);
      if (corr > 32767) corr = 32767;
      if (corr < -32768) corr = -32768;
      ang = angle_now + corr;
      if (ang > int'(lsspd_pkg::ANGLE_MAX)) ang = int'(lsspd_pkg::ANGLE_MAX);
      if (ang < 0) ang = 0;
      angle_now = ang;
      prev_mid  = lsspd_pkg::idx_t'(mid);
    end else begin
      // lost line, or a run centered on sensor zero
      prev_mid = cfg_center;
    end
    r.run_start     = lsspd_pkg::idx_t'(bs);
    r.run_end       = lsspd_pkg::idx_t'(be);
    r.line_position = lsspd_pkg::idx_t'(mid);
    r.line_found    = (mid != 0);
    r.pd_correction = corr[lsspd_pkg::CORR_W-1:0];
    r.steer_angle   = angle_now[lsspd_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  // Mostly single runs as a real bar sees them, plus double runs, edges and noise
  function automatic lsspd_pkg::flag_t sensor_reading();
    int w, pos, kind;
    int bits;
    kind = $urandom_range(0, 19);
    if (kind < 10) begin
      w    = $urandom_range(1, 5);
      pos  = $urandom_range(0, lsspd_pkg::FLAG_W - w);
      bits = ((1 << w) - 1) << pos;
    end else if (kind < 14) begin
      w    = $urandom_range(1, 4);
      pos  = $urandom_range(0, lsspd_pkg::FLAG_W - w);
      bits = ((1 << w) - 1) << pos;
      w    = $urandom_range(1, 4);
      pos  = $urandom_range(0, lsspd_pkg::FLAG_W - w);
      bits = bits | (((1 << w) - 1) << pos);
    end else if (kind < 16) begin
      w    = $urandom_range(1, 4);
      bits = $urandom_range(0, 1) ? ((1 << w) - 1)
                                  : (((1 << w) - 1) << (lsspd_pkg::FLAG_W - w));
    end else if (kind == 16) begin
      bits = 0;
    end else if (kind == 17) begin
      bits = 16'hFFFF;
    end else begin
      bits = $urandom;
    end
    return lsspd_pkg::flag_t'(bits);
  endfunction

  // Register write on the config channel, mirrored into the predictor on the beat
  task automatic reg_write(input logic [lsspd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsspd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lsspd_pkg::REG_CENTER: cfg_center = data[lsspd_pkg::IDX_W-1:0];
      lsspd_pkg::REG_KP:     cfg_kp = data;
      lsspd_pkg::REG_KD:     cfg_kd = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Wait until every queued reading is sent and every result is back, then let it settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_readings.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    logic             nv;
    lsspd_pkg::flag_t nf;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_sensor_flags <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(steer_predict(in_sensor_flags));
        readings_sent++;
      end
      nv = in_valid && !in_ready;
      nf = in_sensor_flags;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_readings.size() != 0) begin
          nv = 1'b1;
          nf = pending_readings.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid        <= nv;
      in_sensor_flags <= nf;
    end
  end

  // Receiver: rotating stall pattern, re-rolled now and then, plus a long hold on request
  logic [7:0] ready_pat  = 8'hFF;
  int         pat_left   = 0;
  int         hold_left  = 0;
  always @(posedge clk) begin
    logic nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_stall_seen != long_stall_reqs) begin
        long_stall_seen = long_stall_reqs;
        hold_left       = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pat = 8'hFF;
            1:       ready_pat = 8'($urandom);
            2:       ready_pat = 8'h01;
            default: ready_pat = 8'($urandom) | 8'($urandom);
          endcase
          pat_left = $urandom_range(16, 64);
        end
        pat_left--;
        nr        = ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[7:1]};
      end
      out_ready <= nr;
    end
  end

  // Result checker
  always @(posedge clk) begin
    lsspd_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: start %0d end %0d pos %0d",
                   $realtime, out_run_start, out_run_end, out_line_position);
      end else begin
        want = expected_results.pop_front();
        if (out_run_start !== want.run_start || out_run_end !== want.run_end ||
            out_line_position !== want.line_position || out_line_found !== want.line_found ||
            out_pd_correction !== want.pd_correction ||
            out_steer_angle !== want.steer_angle) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp start %0d end %0d pos %0d found %0d corr %0d angle %0d",
                     $realtime, want.run_start, want.run_end, want.line_position,
                     want.line_found, $signed(want.pd_correction), want.steer_angle);
            $display("%0t:          got start %0d end %0d pos %0d found %0d corr %0d angle %0d",
                     $realtime, out_run_start, out_run_end, out_line_position,
                     out_line_found, out_pd_correction, out_steer_angle);
          end
        end
      end
    end
  end

  // Stimulus sequencing: directed readings, then one random phase per register setting
  initial begin
    cfg_center = lsspd_pkg::CENTER_RESET;
    cfg_kp     = lsspd_pkg::KP_RESET;
    cfg_kd     = lsspd_pkg::KD_RESET;
    prev_mid   = lsspd_pkg::CENTER_RESET;
    angle_now  = int'(lsspd_pkg::ANGLE_RESET);
    rst_n      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    foreach (directed_readings[i]) pending_readings.push_back(directed_readings[i]);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        reg_write(lsspd_pkg::REG_CENTER, {7'($urandom), 4'(center_tab[ph])});
        if (ph == 3) reg_write(REG_UNUSED, 11'($urandom));
        reg_write(lsspd_pkg::REG_KP, 11'(kp_tab[ph]));
        reg_write(lsspd_pkg::REG_KD, 11'(kd_tab[ph]));
      end else begin
        reg_write(lsspd_pkg::REG_KD, 11'($urandom));
        reg_write(lsspd_pkg::REG_CENTER, 11'($urandom));
        if ($urandom_range(0, 1)) reg_write(REG_UNUSED, 11'($urandom));
        reg_write(lsspd_pkg::REG_KP, 11'($urandom));
      end
      @(negedge clk);
      for (int k = 0; k < READINGS_PER; k++) pending_readings.push_back(sensor_reading());
      // hold the output off long enough for the pipe to back up into the input
      if (ph == 2) long_stall_reqs <= long_stall_reqs + 1;
      wait_drained();
    end

    $display("Covered %0d sensor readings and %0d result beats", readings_sent, results_checked);
    $display("over %0d register writes (center, both gains, unused index) in %0d settings",
             reg_writes, PHASES + 1);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("line_sensor_steering_pd_core_tb: clean");
    end else begin
      $display("line_sensor_steering_pd_core_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("line_sensor_steering_pd_core_tb: errors");
    $finish;
  end

endmodule
